// ===== src/fspm_pkg.sv =====
// ----------------------------------------------------------------------------
// fspm_pkg
// Shared constants, codes and types of the frame slot proposal matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package fspm_pkg;

	localparam int IN_PORTS  = 64;
	localparam int OUT_PORTS = 64;
	localparam int SLOTS_MAX = 16;

	localparam int IN_W    = $clog2(IN_PORTS);
	localparam int OUT_W   = $clog2(OUT_PORTS);
	localparam int SLOT_W  = $clog2(SLOTS_MAX);
	localparam int TBL_W   = SLOT_W + IN_W;
	localparam int FRM_W   = 5;
	localparam int CUT_W   = 7;
	localparam int RND_W   = 5;
	localparam int STAT_W  = 3;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [RND_W-1:0] ROUND_MAX     = RND_W'(31);
	localparam logic [FRM_W-1:0] FRAME_RESET   = FRM_W'(16);
	localparam logic [CUT_W-1:0] CUTOFF_RESET  = CUT_W'(64);

	localparam logic [1:0] REG_FRAME_LEN  = 2'd0;
	localparam logic [1:0] REG_CUTOFF     = 2'd1;
	localparam logic [1:0] REG_SLOT_MODE  = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_PROPOSE = 2'd1,
		CMD_ROUND   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_CUTOFF   = 3'd1,
		ST_OUT_FULL = 3'd2,
		ST_IN_FULL  = 3'd3,
		ST_NO_SLOT  = 3'd4,
		ST_DONE     = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} fspm_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} fspm_ctl_t;

	function automatic logic [FRM_W-1:0] eff_frame(input logic [FRM_W-1:0] f);
		logic [FRM_W-1:0] r;
		r = f;
		if (f == '0)
			r = FRM_W'(1);
		else if (f > FRM_W'(SLOTS_MAX))
			r = FRM_W'(SLOTS_MAX);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/fspm_if.sv =====
// ----------------------------------------------------------------------------
// fspm_if
// Request and response channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface fspm_req_if import fspm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic [IN_W-1:0]   in_port;
	logic [OUT_W-1:0]  dst_port;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, cmd, in_port, dst_port, slot, input ready);
	modport sink   (input valid, cmd, in_port, dst_port, slot, output ready);
endinterface

interface fspm_rsp_if import fspm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] slot_assigned;
	logic              entry_valid;
	logic [OUT_W-1:0]  entry_port;

	modport source (output valid, status, slot_assigned, entry_valid, entry_port,
		input ready);
	modport sink   (input valid, status, slot_assigned, entry_valid, entry_port,
		output ready);
endinterface

`default_nettype wire

// ===== src/frame_slot_proposal_matcher.sv =====
// Flow: memory read at capture, evaluation and write-back in the next cycle
// (execute state); the response beat is registered at the end of execute.
// No new request is taken while one is in execute, set by the read-then-update
// sequence on the port bitmap memories, nor while a response beat is stalled.
// Reset: all batch state reads as cleared at once through per-entry valid
// flops; no clearing sweep. Registers reset to frame 16, cutoff 64, mode 0.
// ----------------------------------------------------------------------------
// frame_slot_proposal_matcher
// Accept stage of a batch switch scheduler with an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_slot_proposal_matcher import fspm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	fspm_req_if.sink                req,
	fspm_rsp_if.source              rsp
);

	logic [FRM_W-1:0] frame_len_q;
	logic [CUT_W-1:0] cutoff_q;
	logic             slot_mode_q;
	logic [1:0]       reg_idx;
	logic             wr_en;
	fspm_ctl_t        ctl;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q  <= FRAME_RESET;
			cutoff_q     <= CUTOFF_RESET;
			slot_mode_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FRAME_LEN:  frame_len_q  <= pwdata[FRM_W-1:0];
				REG_CUTOFF:     cutoff_q     <= pwdata[CUT_W-1:0];
				REG_SLOT_MODE:  slot_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_LEN:  prdata = PDATA_W'(frame_len_q);
			REG_CUTOFF:     prdata = PDATA_W'(cutoff_q);
			REG_SLOT_MODE:  prdata = PDATA_W'(slot_mode_q);
			default:        prdata = '0;
		endcase
	end

	fspm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	fspm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (req.cmd),
		.in_port       (req.in_port),
		.dst_port      (req.dst_port),
		.slot          (req.slot),
		.frame_len     (frame_len_q),
		.cutoff        (cutoff_q),
		.slot_mode     (slot_mode_q),
		.status        (rsp.status),
		.slot_assigned (rsp.slot_assigned),
		.entry_valid   (rsp.entry_valid),
		.entry_port    (rsp.entry_port)
	);

endmodule

`default_nettype wire

// ===== src/fspm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fspm_ctrl
// Handshake sequencer: capture a beat, execute it, hold the response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fspm_ctrl import fspm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output fspm_ctl_t      ctl
);

	fspm_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl         = '0;
		out_valid_d = out_valid_q && !out_ready;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					ctl.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.execute = 1'b1;
				out_valid_d = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/fspm_dp.sv =====
// ----------------------------------------------------------------------------
// fspm_dp
// Datapath: slot bitmaps, proposal counts and schedule memory, slot choice.
// ----------------------------------------------------------------------------
`default_nettype none

module fspm_dp import fspm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fspm_ctl_t         ctl,
	input  wire logic [1:0]        cmd,
	input  wire logic [IN_W-1:0]   in_port,
	input  wire logic [OUT_W-1:0]  dst_port,
	input  wire logic [SLOT_W-1:0] slot,
	input  wire logic [FRM_W-1:0]  frame_len,
	input  wire logic [CUT_W-1:0]  cutoff,
	input  wire logic              slot_mode,
	output logic [STAT_W-1:0]      status,
	output logic [SLOT_W-1:0]      slot_assigned,
	output logic                   entry_valid,
	output logic [OUT_W-1:0]       entry_port
);

	function automatic logic [FRM_W-1:0] popcnt(input logic [SLOTS_MAX-1:0] v);
		logic [FRM_W-1:0] n;
		n = '0;
		for (int i = 0; i < SLOTS_MAX; i++)
			n = n + FRM_W'(v[i]);
		return n;
	endfunction

	// memories, no reset; entries gated by valid flops
	logic [SLOTS_MAX-1:0] ib_mem  [IN_PORTS];
	logic [SLOTS_MAX-1:0] ob_mem  [OUT_PORTS];
	logic [CUT_W-1:0]     pc_mem  [OUT_PORTS];
	logic [OUT_W-1:0]     tbl_mem [SLOTS_MAX*IN_PORTS];

	logic [IN_PORTS-1:0]  ib_vld_q;
	logic [OUT_PORTS-1:0] ob_vld_q;
	logic [OUT_PORTS-1:0] pc_vld_q;
	logic [OUT_PORTS-1:0] closed_q;
	logic [RND_W-1:0]     round_q;
	logic [FRM_W-1:0]     fclr_q;

	cmd_t                 cmd_s1;
	logic [IN_W-1:0]      ip_s1;
	logic [OUT_W-1:0]     op_s1;
	logic [SLOT_W-1:0]    sl_s1;
	logic [SLOTS_MAX-1:0] ib_rd_s1;
	logic [SLOTS_MAX-1:0] ob_rd_s1;
	logic [CUT_W-1:0]     pc_rd_s1;
	logic [OUT_W-1:0]     tbl_rd_s1;

	logic [STAT_W-1:0]    status_q;
	logic [SLOT_W-1:0]    sa_q;
	logic                 ev_q;
	logic [OUT_W-1:0]     ep_q;

	logic [SLOTS_MAX-1:0] ib, ob, fmask, freebits, take_bit;
	logic [CUT_W-1:0]     pc;
	logic [FRM_W-1:0]     frame;
	logic [SLOT_W-1:0]    ff_slot, rslot, sel_slot;
	logic                 ofull, ifull, rbusy, r_in_frame;
	logic                 take, pc_we, close;
	status_t              st;
	logic                 ev;
	logic [OUT_W-1:0]     ep;

	// capture and memory read
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_s1    <= cmd_t'(cmd);
			ip_s1     <= in_port;
			op_s1     <= dst_port;
			sl_s1     <= slot;
			ib_rd_s1  <= ib_mem[in_port];
			ob_rd_s1  <= ob_mem[dst_port];
			pc_rd_s1  <= pc_mem[dst_port];
			tbl_rd_s1 <= tbl_mem[{slot, in_port}];
		end
	end

	always_comb begin
		ib         = ib_vld_q[ip_s1] ? ib_rd_s1 : '0;
		ob         = ob_vld_q[op_s1] ? ob_rd_s1 : '0;
		pc         = pc_vld_q[op_s1] ? pc_rd_s1 : '0;
		frame      = eff_frame(frame_len);
		for (int i = 0; i < SLOTS_MAX; i++)
			fmask[i] = FRM_W'(i) < frame;
		freebits   = ~(ib | ob) & fmask;
		ff_slot    = '0;
		for (int i = SLOTS_MAX - 1; i >= 0; i--)
			if (freebits[i])
				ff_slot = SLOT_W'(i);
		ofull      = popcnt(ob) >= fclr_q;
		ifull      = popcnt(ib) >= fclr_q;
		rslot      = round_q[SLOT_W-1:0];
		r_in_frame = round_q < frame;
		rbusy      = ib[rslot] || ob[rslot];
	end

	always_comb begin
		st       = ST_DONE;
		take     = 1'b0;
		pc_we    = 1'b0;
		close    = 1'b0;
		sel_slot = '0;
		ev       = 1'b0;
		ep       = '0;
		unique case (cmd_s1) inside
			CMD_CLEAR, CMD_ROUND: begin
				st = ST_DONE;
			end
			CMD_PROPOSE: begin
				st = ST_CUTOFF;
				if (pc < cutoff) begin
					pc_we = 1'b1;
					if (ofull || closed_q[op_s1]) begin
						st = ST_OUT_FULL;
					end else if (ifull) begin
						st = ST_IN_FULL;
					end else if (slot_mode) begin
						close = 1'b1;
						st    = ST_NO_SLOT;
						if (r_in_frame && !rbusy) begin
							take     = 1'b1;
							sel_slot = rslot;
							st       = ST_OK;
						end
					end else if (freebits == '0) begin
						st = ST_NO_SLOT;
					end else begin
						take     = 1'b1;
						sel_slot = ff_slot;
						st       = ST_OK;
					end
				end
			end
			CMD_READ: begin
				ev = ib[sl_s1];
				ep = ev ? tbl_rd_s1 : '0;
			end
			default: begin
				st = ST_DONE;
			end
		endcase
		take_bit = take ? (SLOTS_MAX'(1) << sel_slot) : '0;
	end

	// write back
	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			if (take) begin
				ib_mem[ip_s1]             <= ib | take_bit;
				ob_mem[op_s1]             <= ob | take_bit;
				tbl_mem[{sel_slot, ip_s1}] <= op_s1;
			end
			if (pc_we)
				pc_mem[op_s1] <= pc + CUT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ib_vld_q <= '0;
			ob_vld_q <= '0;
			pc_vld_q <= '0;
			closed_q <= '0;
			round_q  <= '0;
			fclr_q   <= FRAME_RESET;
		end else if (ctl.execute) begin
			if (cmd_s1 == CMD_CLEAR) begin
				ib_vld_q <= '0;
				ob_vld_q <= '0;
				pc_vld_q <= '0;
				closed_q <= '0;
				round_q  <= '0;
				fclr_q   <= frame;
			end else if (cmd_s1 == CMD_ROUND) begin
				pc_vld_q <= '0;
				closed_q <= '0;
				if (round_q < ROUND_MAX)
					round_q <= round_q + RND_W'(1);
			end else begin
				if (pc_we)
					pc_vld_q[op_s1] <= 1'b1;
				if (close)
					closed_q[op_s1] <= 1'b1;
				if (take) begin
					ib_vld_q[ip_s1] <= 1'b1;
					ob_vld_q[op_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			status_q <= st;
			sa_q     <= sel_slot;
			ev_q     <= ev;
			ep_q     <= ep;
		end
	end

	assign status        = status_q;
	assign slot_assigned = sa_q;
	assign entry_valid   = ev_q;
	assign entry_port    = ep_q;

endmodule

`default_nettype wire

// ===== src/fspm_chk.sv =====
// ----------------------------------------------------------------------------
// fspm_chk
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fspm_chk import fspm_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [STAT_W-1:0] status,
	input wire logic [SLOT_W-1:0] slot_assigned,
	input wire logic              entry_valid,
	input wire logic [OUT_W-1:0]  entry_port
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response beat dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in flight");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid ##1 out_valid)
		else $error("response not presented two cycles after request");

	a_slot_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> slot_assigned == '0)
		else $error("slot given without accept");

	a_entry_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> entry_port == '0)
		else $error("port shown for empty entry");

endmodule

bind frame_slot_proposal_matcher fspm_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.status        (rsp.status),
	.slot_assigned (rsp.slot_assigned),
	.entry_valid   (rsp.entry_valid),
	.entry_port    (rsp.entry_port)
);

`default_nettype wire

// ===== tb/fspm_sched_checker.sv =====
// ----------------------------------------------------------------------------
// fspm_sched_checker
// Watches the register port and both channels of the proposal matcher, keeps
// its own copy of the batch schedule state and compares every response beat
// with the predicted one, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fspm_sched_checker import fspm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	fspm_req_if                req,
	fspm_rsp_if                rsp,
	output int                 fail_cnt,
	output int                 pending
);

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_assigned;
		logic              entry_valid;
		logic [OUT_W-1:0]  entry_port;
	} sched_rsp_t;

	logic [FRM_W-1:0]     frame_reg;
	logic [CUT_W-1:0]     cutoff_reg;
	logic                 mode_reg;

	logic [SLOTS_MAX-1:0] in_busy   [IN_PORTS];
	logic [SLOTS_MAX-1:0] out_busy  [OUT_PORTS];
	logic [FRM_W-1:0]     in_free   [IN_PORTS];
	logic [FRM_W-1:0]     out_free  [OUT_PORTS];
	logic [OUT_W:0]       sched_tbl [SLOTS_MAX*IN_PORTS];
	logic [CUT_W-1:0]     offer_cnt [OUT_PORTS];
	logic                 out_shut  [OUT_PORTS];
	logic [RND_W-1:0]     round_no;

	sched_rsp_t rsp_expect_q[$];
	int mismatches = 0;
	int depth = 0;

	assign fail_cnt = mismatches;
	assign pending  = depth;

	function automatic logic [FRM_W-1:0] frame_eff();
		if (frame_reg == '0)
			return FRM_W'(1);
		if (frame_reg > FRM_W'(SLOTS_MAX))
			return FRM_W'(SLOTS_MAX);
		return frame_reg;
	endfunction

	task automatic clear_batch();
		for (int i = 0; i < IN_PORTS; i++) begin
			in_busy[i] = '0;
			in_free[i] = frame_eff();
		end
		for (int o = 0; o < OUT_PORTS; o++) begin
			out_busy[o]  = '0;
			out_free[o]  = frame_eff();
			offer_cnt[o] = '0;
			out_shut[o]  = 1'b0;
		end
		foreach (sched_tbl[k])
			sched_tbl[k] = '0;
		round_no = '0;
	endtask

	task automatic predict_response(input cmd_t c, input logic [IN_W-1:0] ip,
		input logic [OUT_W-1:0] op, input logic [SLOT_W-1:0] sl, output sched_rsp_t r);
		logic [FRM_W-1:0]     f;
		logic [SLOTS_MAX-1:0] open;
		logic [SLOT_W-1:0]    s;
		logic                 grant;
		logic [OUT_W:0]       e;
		r = '{status: ST_DONE, default: '0};
		f = frame_eff();
		s = '0;
		grant = 1'b0;
		case (c)
			CMD_CLEAR: clear_batch();
			CMD_PROPOSE: begin
				if (offer_cnt[op] >= cutoff_reg) begin
					r.status = ST_CUTOFF;
				end else begin
					offer_cnt[op]++;
					if (out_free[op] == '0 || out_shut[op]) begin
						r.status = ST_OUT_FULL;
					end else if (in_free[ip] == '0) begin
						r.status = ST_IN_FULL;
					end else if (mode_reg) begin
						// round-slot: output closes for the round whatever happens
						out_shut[op] = 1'b1;
						if (round_no >= f || in_busy[ip][round_no[SLOT_W-1:0]] ||
							out_busy[op][round_no[SLOT_W-1:0]]) begin
							r.status = ST_NO_SLOT;
						end else begin
							grant = 1'b1;
							s = round_no[SLOT_W-1:0];
						end
					end else begin
						open = ~(in_busy[ip] | out_busy[op]);
						if (f < FRM_W'(SLOTS_MAX))
							open &= (SLOTS_MAX'(1) << f) - SLOTS_MAX'(1);
						if (open == '0) begin
							r.status = ST_NO_SLOT;
						end else begin
							grant = 1'b1;
							for (int k = SLOTS_MAX - 1; k >= 0; k--)
								if (open[k])
									s = SLOT_W'(k);
						end
					end
				end
				if (grant) begin
					in_busy[ip][s]  = 1'b1;
					out_busy[op][s] = 1'b1;
					if (in_free[ip] != '0)
						in_free[ip]--;
					if (out_free[op] != '0)
						out_free[op]--;
					sched_tbl[{s, ip}] = {1'b1, op};
					r.status = ST_OK;
					r.slot_assigned = s;
				end
			end
			CMD_ROUND: begin
				for (int o = 0; o < OUT_PORTS; o++) begin
					offer_cnt[o] = '0;
					out_shut[o]  = 1'b0;
				end
				if (round_no < ROUND_MAX)
					round_no++;
			end
			default: begin
				e = sched_tbl[{sl, ip}];
				r.entry_valid = e[OUT_W];
				r.entry_port  = e[OUT_W-1:0];
			end
		endcase
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_rsp_t nxt;
		sched_rsp_t want;
		if (!arst_n) begin
			frame_reg  = FRAME_RESET;
			cutoff_reg = CUTOFF_RESET;
			mode_reg   = 1'b0;
			clear_batch();
			rsp_expect_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_FRAME_LEN:  frame_reg  = pwdata[FRM_W-1:0];
					REG_CUTOFF:     cutoff_reg = pwdata[CUT_W-1:0];
					REG_SLOT_MODE:  mode_reg   = pwdata[0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				predict_response(cmd_t'(req.cmd), req.in_port, req.dst_port, req.slot, nxt);
				rsp_expect_q = {rsp_expect_q, nxt};
			end
			if (rsp.valid && rsp.ready) begin
				if (rsp_expect_q.size() == 0) begin
					$error("response beat with no request outstanding");
					mismatches++;
				end else begin
					want = rsp_expect_q.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("slot_assigned", want.slot_assigned, rsp.slot_assigned);
					check_field("entry_valid", want.entry_valid, rsp.entry_valid);
					check_field("entry_port", want.entry_port, rsp.entry_port);
				end
			end
		end
		depth = rsp_expect_q.size();
	end

endmodule

// ===== tb/tb_frame_slot_proposal_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_frame_slot_proposal_matcher
// Drives clear, proposal, round and read beats into the matcher under a range
// of frame, cutoff and slot-mode settings and idling patterns; a checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frame_slot_proposal_matcher import fspm_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_PAUSE = 4;
	localparam int PHASE_ITEMS = 40;
	localparam int N_PHASES    = 8;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int gap_pct   = 0;
	int stall_pct = 0;
	int hold_req  = 0;
	int hold_seen = 0;
	int sent      = 0;
	int cycle_cnt = 0;
	int cur_frame = 16;
	int fail_cnt;
	int pending;

	int ph_frame [N_PHASES] = '{16, 1, 4, 16, 2, 8, 5, 16};
	int ph_cut   [N_PHASES] = '{64, 1, 3, 64, 64, 2, 64, 7};
	int ph_mode  [N_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1};
	int ph_gap   [N_PHASES] = '{0, 70, 0, 20, 70, 0, 20, 0};
	int ph_stall [N_PHASES] = '{0, 0, 70, 20, 0, 70, 20, 0};

	fspm_req_if req();
	fspm_rsp_if rsp();

	frame_slot_proposal_matcher dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.req(req), .rsp(rsp)
	);

	fspm_sched_checker chk (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.req(req), .rsp(rsp), .fail_cnt(fail_cnt), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_frame_slot_proposal_matcher failed");
			$finish;
		end
	end

	// response side: random stalls, plus one long hold-off on request
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				rsp.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(input cmd_t c, input int ip, input int op, input int sl);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			req.valid = 1'b0;
		end
		@(negedge clk);
		req.valid    = 1'b1;
		req.cmd      = c;
		req.in_port  = IN_W'(ip);
		req.dst_port = OUT_W'(op);
		req.slot     = SLOT_W'(sl);
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'({idx, 2'b00});
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_cfg(input int f, input int cut, input int mode);
		drain();
		apb_write(REG_FRAME_LEN, PDATA_W'(f));
		apb_write(REG_CUTOFF, PDATA_W'(cut));
		apb_write(REG_SLOT_MODE, PDATA_W'(mode));
		cur_frame = f;
	endtask

	// one batch: optional clear, rounds of rising-input proposals, then reads
	task automatic run_batch();
		int n_rounds;
		int n_offers;
		int span;
		int step;
		int ip;
		if ($urandom_range(99) < 85)
			send(CMD_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(15));
		n_rounds = $urandom_range(1, cur_frame + 2);
		for (int r = 0; r < n_rounds; r++) begin
			span = ($urandom_range(3) == 0) ? 64 : 8;
			step = (span == 64) ? 8 : 1;
			n_offers = $urandom_range(2, 10);
			ip = $urandom_range(0, span / 2);
			for (int n = 0; n < n_offers; n++) begin
				if ($urandom_range(99) < 8)
					send(cmd_t'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
						$urandom_range(15));
				else
					send(CMD_PROPOSE, ip, $urandom_range(span - 1), $urandom_range(15));
				ip += $urandom_range(0, step);
				if (ip > span - 1)
					ip = span - 1;
			end
			send(CMD_ROUND, $urandom_range(63), $urandom_range(63), $urandom_range(15));
		end
		repeat ($urandom_range(1, 4))
			send(CMD_READ, $urandom_range(span - 1), $urandom_range(63), $urandom_range(15));
	endtask

	initial begin
		int goal;
		req.valid    = 1'b0;
		req.cmd      = CMD_CLEAR;
		req.in_port  = '0;
		req.dst_port = '0;
		req.slot     = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		send(CMD_READ, 63, 0, 15);
		send(CMD_PROPOSE, 0, 0, 0);
		send(CMD_PROPOSE, 0, 63, 0);
		send(CMD_PROPOSE, 63, 63, 15);
		send(CMD_READ, 0, 0, 1);
		send(CMD_ROUND, 0, 0, 0);
		set_cfg(16, 1, 0);
		send(CMD_PROPOSE, 1, 5, 0);
		send(CMD_PROPOSE, 2, 5, 0);
		set_cfg(1, 64, 0);
		send(CMD_CLEAR, 0, 0, 0);
		send(CMD_PROPOSE, 3, 7, 0);
		send(CMD_PROPOSE, 3, 8, 0);
		send(CMD_PROPOSE, 4, 7, 0);
		set_cfg(2, 64, 0);
		send(CMD_CLEAR, 0, 0, 0);
		send(CMD_PROPOSE, 12, 22, 0);
		send(CMD_PROPOSE, 13, 23, 0);
		send(CMD_PROPOSE, 13, 24, 0);
		send(CMD_PROPOSE, 12, 24, 0);
		// frame grows mid-batch: free counts kept, wider slot search
		set_cfg(16, 64, 0);
		send(CMD_PROPOSE, 12, 24, 0);
		set_cfg(16, 64, 1);
		send(CMD_CLEAR, 0, 0, 0);
		send(CMD_PROPOSE, 5, 6, 0);
		send(CMD_PROPOSE, 7, 6, 0);
		send(CMD_ROUND, 0, 0, 0);
		send(CMD_PROPOSE, 5, 9, 0);
		send(CMD_PROPOSE, 5, 10, 0);
		set_cfg(2, 64, 1);
		send(CMD_ROUND, 0, 0, 0);
		send(CMD_PROPOSE, 8, 11, 0);
		send(CMD_PROPOSE, 9, 11, 0);

		// random phases
		for (int p = 0; p < N_PHASES; p++) begin
			set_cfg(ph_frame[p], ph_cut[p], ph_mode[p]);
			gap_pct   = ph_gap[p];
			stall_pct = ph_stall[p];
			if (p == 0)
				hold_req++;
			if (p == 5)
				repeat (33) send(CMD_ROUND, $urandom_range(63), $urandom_range(63), 0);
			goal = sent + PHASE_ITEMS;
			while (sent < goal)
				run_batch();
		end

		gap_pct   = 0;
		stall_pct = 0;
		drain();
		if (fail_cnt == 0)
			$display("tb_frame_slot_proposal_matcher passed");
		else
			$display("tb_frame_slot_proposal_matcher failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/fspm_pkg.sv
src/fspm_if.sv
src/fspm_ctrl.sv
src/fspm_dp.sv
src/frame_slot_proposal_matcher.sv
src/fspm_chk.sv
tb/fspm_sched_checker.sv
tb/tb_frame_slot_proposal_matcher.sv
